>>> src/sbh_pkg.sv
package sbh_pkg;

    localparam int WORD_W      = 32;
    localparam int HASH_WORDS  = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [3:0] LEN_HI_WORD  = 4'd14;
    localparam logic [3:0] LEN_LO_WORD  = 4'd15;
    localparam logic [2:0] LAST_WORD    = 3'd7;

    localparam logic [31:0] HASH_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_MARK,
        ST_PAD_FILL,
        ST_PAD_ZERO,
        ST_PAD_LEN_HI,
        ST_PAD_LEN_LO,
        ST_OUT_RD,
        ST_OUT_CAP
    } state_t;

    // Controls from the sequencer to the round datapath
    typedef struct packed {
        logic load;       // shift a chaining word into the working set
        logic word_load;  // take schedule word 0 from the block buffer
        logic round;      // run one compression round
        logic update;     // rotate the working set during write-back
    } rnd_ctl_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> src/sha256_byte_stream_hasher.sv
// SHA-256 hasher fed one message byte per input word. s_tdata carries the
// byte, s_tuser says whether the byte is present, and s_tlast ends the
// message; a last word without a byte finishes the message as it stands, so
// a lone empty last word gives the digest of the empty message. Bytes are
// taken one per cycle while s_tready is high and packed big-endian into a
// 16-word block buffer memory. The 64th byte of a block starts the
// compression, which holds s_tready low while it reads the chaining words
// from the hash memory, runs 64 rounds on one shared round unit, and adds
// the working set back into the hash memory. The throughput of a steady
// stream is therefore set by the single round unit. After the last word the
// block writes the padding marker, zero words and the 64-bit bit length into
// the buffer, runs one more compression, or two when 8 or fewer bytes of
// room remained, and then sends the eight digest words, word 0 first, on
// m_tdata with the index on m_tuser and m_tlast on word 7, reading each
// word from the hash memory before it enters the output register. The
// message bit count wraps at 2^64. Once word 7 sits in the output register
// the hash memory returns to the initial values and the next message is
// accepted while that word waits.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // digest_last
);

    sbh_pkg::state_t state_reg, state_next;
    sbh_pkg::state_t ret_reg, ret_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] word_reg, word_next;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_idx_reg;
    logic        out_last_reg;
    logic        out_load;

    logic        buf_we;
    logic [3:0]  buf_waddr;
    logic [31:0] buf_wdata;
    logic [3:0]  buf_raddr;
    logic [31:0] buf_rd;

    logic        hash_we;
    logic [2:0]  hash_waddr;
    logic [31:0] hash_wdata;
    logic        hash_re;
    logic [2:0]  hash_raddr;
    logic        hash_clear;
    logic [31:0] hash_rd;

    sbh_pkg::rnd_ctl_t ctl;
    logic [31:0] a_word;
    logic [31:0] mark_word;

    sbh_block_ram u_block_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rd)
    );

    sbh_hash_ram u_hash_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .re    (hash_re),
        .raddr (hash_raddr),
        .clear (hash_clear),
        .rdata (hash_rd)
    );

    sbh_round u_round (
        .clk       (clk),
        .ctl       (ctl),
        .round_idx (cnt_reg),
        .hash_rd   (hash_rd),
        .buf_rd    (buf_rd),
        .a_word    (a_word)
    );

    assign s_tready = (state_reg == sbh_pkg::ST_IDLE);

    // Word holding the padding marker: keep earlier bytes, clear later ones
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    mark_word = {sbh_pkg::PAD_MARK, 24'h0};
            2'd1:    mark_word = {word_reg[31:24], sbh_pkg::PAD_MARK, 16'h0};
            2'd2:    mark_word = {word_reg[31:16], sbh_pkg::PAD_MARK, 8'h0};
            default: mark_word = {word_reg[31:8], sbh_pkg::PAD_MARK};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        word_next  = word_reg;

        buf_we     = 1'b0;
        buf_waddr  = fill_reg[5:2];
        buf_wdata  = '0;
        buf_raddr  = cnt_reg[3:0] + 4'd2;

        hash_we    = 1'b0;
        hash_waddr = cnt_reg[2:0] - 3'd1;
        hash_wdata = hash_rd + a_word;
        hash_re    = 1'b0;
        hash_raddr = cnt_reg[2:0];
        hash_clear = 1'b0;

        ctl        = '0;
        out_load   = 1'b0;

        case (state_reg)
            sbh_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        // Place the byte in its lane, big-endian
                        case (fill_reg[1:0])
                            2'd0:    word_next[31:24] = s_tdata;
                            2'd1:    word_next[23:16] = s_tdata;
                            2'd2:    word_next[15:8]  = s_tdata;
                            default: word_next[7:0]   = s_tdata;
                        endcase
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            buf_we    = 1'b1;
                            buf_wdata = {word_reg[31:8], s_tdata};
                        end
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = sbh_pkg::ST_LOAD;
                            cnt_next   = '0;
                            ret_next   = s_tlast ? sbh_pkg::ST_PAD_MARK : sbh_pkg::ST_IDLE;
                        end
                        else if (s_tlast)
                        begin
                            state_next = sbh_pkg::ST_PAD_MARK;
                        end
                    end
                    else if (s_tlast)
                    begin
                        state_next = sbh_pkg::ST_PAD_MARK;
                    end
                end
            end

            sbh_pkg::ST_PAD_MARK:
            begin
                buf_we    = 1'b1;
                buf_wdata = mark_word;
                cnt_next  = {2'b00, fill_reg[5:2]} + 6'd1;
                // No room for the length after the marker: finish this block first
                if (fill_reg[5:2] >= sbh_pkg::LEN_HI_WORD)
                begin
                    state_next = sbh_pkg::ST_PAD_FILL;
                end
                else
                begin
                    state_next = sbh_pkg::ST_PAD_ZERO;
                end
            end

            sbh_pkg::ST_PAD_FILL:
            begin
                if (cnt_reg == 6'(sbh_pkg::BLOCK_WORDS))
                begin
                    state_next = sbh_pkg::ST_LOAD;
                    cnt_next   = '0;
                    ret_next   = sbh_pkg::ST_PAD_ZERO;
                end
                else
                begin
                    buf_we    = 1'b1;
                    buf_waddr = cnt_reg[3:0];
                    cnt_next  = cnt_reg + 6'd1;
                end
            end

            sbh_pkg::ST_PAD_ZERO:
            begin
                if (cnt_reg >= {2'b00, sbh_pkg::LEN_HI_WORD})
                begin
                    state_next = sbh_pkg::ST_PAD_LEN_HI;
                end
                else
                begin
                    buf_we    = 1'b1;
                    buf_waddr = cnt_reg[3:0];
                    cnt_next  = cnt_reg + 6'd1;
                end
            end

            sbh_pkg::ST_PAD_LEN_HI:
            begin
                buf_we     = 1'b1;
                buf_waddr  = sbh_pkg::LEN_HI_WORD;
                buf_wdata  = bits_reg[63:32];
                state_next = sbh_pkg::ST_PAD_LEN_LO;
            end

            sbh_pkg::ST_PAD_LEN_LO:
            begin
                buf_we     = 1'b1;
                buf_waddr  = sbh_pkg::LEN_LO_WORD;
                buf_wdata  = bits_reg[31:0];
                state_next = sbh_pkg::ST_LOAD;
                cnt_next   = '0;
                ret_next   = sbh_pkg::ST_OUT_RD;
            end

            sbh_pkg::ST_LOAD:
            begin
                // Read chaining words, then prefetch schedule words 0 and 1
                hash_re   = (cnt_reg < 6'(sbh_pkg::HASH_WORDS));
                ctl.load  = (cnt_reg != 6'd0);
                buf_raddr = cnt_reg[3:0] - 4'd7;
                if (cnt_reg == 6'(sbh_pkg::HASH_WORDS))
                begin
                    ctl.word_load = 1'b1;
                    state_next    = sbh_pkg::ST_ROUND;
                    cnt_next      = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            sbh_pkg::ST_ROUND:
            begin
                ctl.round = 1'b1;
                if (cnt_reg == 6'(sbh_pkg::ROUNDS - 1))
                begin
                    state_next = sbh_pkg::ST_UPDATE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            sbh_pkg::ST_UPDATE:
            begin
                // Read word n while writing back word n-1
                hash_re = (cnt_reg < 6'(sbh_pkg::HASH_WORDS));
                if (cnt_reg != 6'd0)
                begin
                    hash_we    = 1'b1;
                    ctl.update = 1'b1;
                end
                if (cnt_reg == 6'(sbh_pkg::HASH_WORDS))
                begin
                    state_next = ret_reg;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end

            sbh_pkg::ST_OUT_RD:
            begin
                hash_re    = 1'b1;
                state_next = sbh_pkg::ST_OUT_CAP;
            end

            sbh_pkg::ST_OUT_CAP:
            begin
                // Hold the read data until the output register frees up
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (cnt_reg[2:0] == sbh_pkg::LAST_WORD)
                    begin
                        hash_clear = 1'b1;
                        fill_next  = '0;
                        bits_next  = '0;
                        cnt_next   = '0;
                        state_next = sbh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 6'd1;
                        state_next = sbh_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = sbh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbh_pkg::ST_IDLE;
            ret_reg       <= sbh_pkg::ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (out_load)
        begin
            out_word_reg <= hash_rd;
            out_idx_reg  <= cnt_reg[2:0];
            out_last_reg <= (cnt_reg[2:0] == sbh_pkg::LAST_WORD);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> src/sbh_block_ram.sv
module sbh_block_ram (
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);

    logic [31:0] block_mem [sbh_pkg::BLOCK_WORDS];
    logic [31:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            block_mem[waddr] <= wdata;
        end
        rd_reg <= block_mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

>>> src/sbh_hash_ram.sv
module sbh_hash_ram (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [2:0]  waddr,
    input  logic [31:0] wdata,
    input  logic        re,
    input  logic [2:0]  raddr,
    input  logic        clear,
    output logic [31:0] rdata
);

    logic [31:0] hash_mem [sbh_pkg::HASH_WORDS];
    logic [31:0] rd_reg;
    logic [2:0]  rd_idx_reg;
    logic [sbh_pkg::HASH_WORDS-1:0] valid_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hash_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg     <= hash_mem[raddr];
            rd_idx_reg <= raddr;
        end
    end

    // An entry not written since the last clear reads as its initial value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : sbh_pkg::HASH_INIT[rd_idx_reg];

endmodule

>>> src/sbh_round.sv
module sbh_round (
    input  logic              clk,
    input  sbh_pkg::rnd_ctl_t ctl,
    input  logic [5:0]        round_idx,
    input  logic [31:0]       hash_rd,
    input  logic [31:0]       buf_rd,
    output logic [31:0]       a_word
);

    logic [31:0] wv_reg   [8];
    logic [31:0] wv_next  [8];
    logic [31:0] sched_reg  [16];
    logic [31:0] sched_next [16];
    logic [31:0] w_cur_reg;
    logic [31:0] w_cur_next;
    logic [31:0] w_calc;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb
    begin
        ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1  = wv_reg[7] + sbh_pkg::big_sigma1(wv_reg[4]) + ch
              + sbh_pkg::ROUND_K[round_idx] + w_cur_reg;
        t2  = sbh_pkg::big_sigma0(wv_reg[0]) + maj;

        // Next schedule word from w[t-2], w[t-7], w[t-15], w[t-16]
        w_calc = sbh_pkg::small_sigma1(sched_reg[15]) + sched_reg[10]
                 + sbh_pkg::small_sigma0(sched_reg[2]) + sched_reg[1];

        wv_next    = wv_reg;
        sched_next = sched_reg;
        w_cur_next = w_cur_reg;

        if (ctl.load || ctl.update)
        begin
            for (int i = 0; i < 7; i++)
            begin
                wv_next[i] = wv_reg[i+1];
            end
            wv_next[7] = ctl.load ? hash_rd : wv_reg[0];
        end
        else if (ctl.round)
        begin
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
        end

        if (ctl.word_load)
        begin
            w_cur_next = buf_rd;
        end
        else if (ctl.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_next[i] = sched_reg[i+1];
            end
            sched_next[15] = w_cur_reg;
            // First sixteen words come straight from the block buffer
            w_cur_next = (round_idx < 6'd15) ? buf_rd : w_calc;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg    <= wv_next;
        sched_reg <= sched_next;
        w_cur_reg <= w_cur_next;
    end

    assign a_word = wv_reg[0];

endmodule
